// File: rtl/core/olb_pkg.sv
// Shared types and constants for the octree level builder.
package olb_pkg;

    localparam int unsigned SLOT_BITS = 3;
    localparam int unsigned NUM_SLOTS = 8;

    typedef logic [SLOT_BITS-1:0] slot_t;
    typedef logic [NUM_SLOTS-1:0] occ_t;

    // Control part of one classified request passed from front to back.
    typedef struct packed {
        logic  flush_before;  // open group has a different parent: emit it first
        logic  last;          // final item of the level: emit after absorbing
        slot_t slot;          // octant chosen by the low code bits
    } cmd_ctl_t;

endpackage

// File: rtl/core/olb_queue2.sv
// Two-entry register queue used between front and back and as output buffer.
module olb_queue2 #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: rtl/core/olb_front.sv
// Front end: accept items, track the open parent and classify each request.
module olb_front
    import olb_pkg::*;
#(
    parameter int unsigned CODE_BITS   = 63,
    parameter int unsigned INDEX_BITS  = 32,
    parameter int unsigned PARENT_BITS = 60
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [CODE_BITS-1:0]   code,
    input  logic [INDEX_BITS-1:0]  child,
    input  logic                   last,
    input  logic                   q_full,
    output logic                   q_push,
    output cmd_ctl_t               q_ctl,
    output logic [PARENT_BITS-1:0] q_parent,
    output logic [INDEX_BITS-1:0]  q_child
);

    localparam int unsigned EXT_BITS = CODE_BITS + PARENT_BITS;

    logic                   open_reg;
    logic                   open_next;
    logic [PARENT_BITS-1:0] parent_reg;
    logic [PARENT_BITS-1:0] parent_next;
    logic [EXT_BITS-1:0]    code_ext;
    logic [PARENT_BITS-1:0] item_parent;

    assign code_ext    = EXT_BITS'(code);
    assign item_parent = code_ext[SLOT_BITS +: PARENT_BITS];

    assign q_push             = push && !q_full;
    assign q_ctl.flush_before = open_reg && (item_parent != parent_reg);
    assign q_ctl.last         = last;
    assign q_ctl.slot         = code_ext[SLOT_BITS-1:0];
    assign q_parent           = item_parent;
    assign q_child            = child;

    // A last item closes the group; any other item leaves its parent open.
    always_comb
    begin
        open_next   = open_reg;
        parent_next = parent_reg;
        if (q_push)
        begin
            open_next   = !last;
            parent_next = item_parent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg   <= 1'b0;
            parent_reg <= '0;
        end
        else
        begin
            open_reg   <= open_next;
            parent_reg <= parent_next;
        end
    end

endmodule

// File: rtl/core/olb_back.sv
// Back end: assemble sibling groups and push finished node records.
module olb_back
    import olb_pkg::*;
#(
    parameter int unsigned INDEX_BITS  = 32,
    parameter int unsigned PARENT_BITS = 60,
    parameter int unsigned REC_BITS    = 357
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_empty,
    input  cmd_ctl_t               cmd_ctl,
    input  logic [PARENT_BITS-1:0] cmd_parent,
    input  logic [INDEX_BITS-1:0]  cmd_child,
    output logic                   cmd_pop,
    input  logic                   out_full,
    output logic                   rec_push,
    output logic [REC_BITS-1:0]    rec
);

    logic [INDEX_BITS-1:0]  children_reg  [NUM_SLOTS];
    logic [INDEX_BITS-1:0]  children_next [NUM_SLOTS];
    logic [INDEX_BITS-1:0]  base_children [NUM_SLOTS];
    logic [INDEX_BITS-1:0]  new_children  [NUM_SLOTS];
    logic [INDEX_BITS-1:0]  emit_children [NUM_SLOTS];
    occ_t                   mask_reg;
    occ_t                   mask_next;
    occ_t                   base_mask;
    occ_t                   new_mask;
    occ_t                   emit_mask;
    logic [PARENT_BITS-1:0] parent_reg;
    logic [PARENT_BITS-1:0] parent_next;
    logic [PARENT_BITS-1:0] emit_parent;
    logic [INDEX_BITS-1:0]  node_reg;
    logic [INDEX_BITS-1:0]  node_next;
    logic                   half_reg;
    logic                   half_next;
    logic                   flush_first;
    logic                   needs_push;
    logic                   go;
    logic [NUM_SLOTS*INDEX_BITS-1:0] children_flat;

    // Emit the old group first; a following last is finished on the next pass.
    assign flush_first = cmd_ctl.flush_before && !half_reg;
    assign needs_push  = flush_first || cmd_ctl.last;
    assign go          = !cmd_empty && (!needs_push || !out_full);
    assign cmd_pop     = go && !(flush_first && cmd_ctl.last);
    assign rec_push    = go && needs_push;

    always_comb
    begin
        base_mask = flush_first ? '0 : mask_reg;
        new_mask  = base_mask | (occ_t'(1) << cmd_ctl.slot);
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            base_children[i] = flush_first ? '1 : children_reg[i];
            new_children[i]  = (cmd_ctl.slot == slot_t'(i)) ? cmd_child : base_children[i];
            emit_children[i] = flush_first ? children_reg[i] : new_children[i];
            children_flat[i*INDEX_BITS +: INDEX_BITS] = emit_children[i];
        end
        emit_mask   = flush_first ? mask_reg : new_mask;
        emit_parent = flush_first ? parent_reg : cmd_parent;
    end

    assign rec = {node_reg, emit_parent, emit_mask, children_flat, !flush_first};

    always_comb
    begin
        mask_next   = mask_reg;
        parent_next = parent_reg;
        node_next   = node_reg;
        half_next   = half_reg;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            children_next[i] = children_reg[i];
        end
        if (go)
        begin
            if (needs_push)
            begin
                node_next = node_reg + INDEX_BITS'(1);
            end
            if (cmd_ctl.last)
            begin
                // Either half of a last request leaves the group empty.
                mask_next   = '0;
                parent_next = '0;
                half_next   = flush_first;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    children_next[i] = '1;
                end
            end
            else
            begin
                mask_next   = new_mask;
                parent_next = cmd_parent;
                half_next   = 1'b0;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    children_next[i] = new_children[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg   <= '0;
            parent_reg <= '0;
            node_reg   <= '0;
            half_reg   <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                children_reg[i] <= '1;
            end
        end
        else
        begin
            mask_reg   <= mask_next;
            parent_reg <= parent_next;
            node_reg   <= node_next;
            half_reg   <= half_next;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                children_reg[i] <= children_next[i];
            end
        end
    end

endmodule

// File: rtl/core/octree_level_builder.sv
// Top level of the octree level builder: front end, request queue, back end, node buffer.
//
// The block takes a stream of (Morton code, child index) requests sorted by
// code and groups siblings, those whose codes agree above the low three bits,
// into one octree node: the low three bits pick the octant, set its occupancy
// bit and fill its child slot, and empty octants read as all ones. A node is
// emitted when the parent code changes or after a request marked last; that
// node carries level_end. Node indices count up from zero after reset and keep
// running across levels, wrapping at 2^INDEX_BITS. One request is taken every
// clock cycle while full is low. A request that both changes the parent and is
// marked last makes two nodes and holds the back end for a second pass; the
// two-entry queue in front of it buffers requests meanwhile, and full rises when
// that queue fills. A node passes through the request queue and the node buffer
// before it appears on the outputs, and the two-entry node buffer can take one
// more node while a node waits to be popped. Both sides behave as queues:
// push/full in, empty/pop out.
module octree_level_builder
    import olb_pkg::*;
#(
    parameter int unsigned CODE_BITS  = 63,
    parameter int unsigned INDEX_BITS = 32,
    // A parent code is the code without its octant bits; keep one bit at minimum.
    localparam int unsigned PARENT_BITS = (CODE_BITS > SLOT_BITS) ? CODE_BITS - SLOT_BITS : 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [CODE_BITS-1:0]    code,
    input  logic [INDEX_BITS-1:0]   child,
    input  logic                    last,
    output logic                    empty,
    input  logic                    pop,
    output logic [INDEX_BITS-1:0]   node_index,
    output logic [PARENT_BITS-1:0]  parent_code,
    output logic [NUM_SLOTS-1:0]    occupancy,
    output logic [INDEX_BITS-1:0]   child_0,
    output logic [INDEX_BITS-1:0]   child_1,
    output logic [INDEX_BITS-1:0]   child_2,
    output logic [INDEX_BITS-1:0]   child_3,
    output logic [INDEX_BITS-1:0]   child_4,
    output logic [INDEX_BITS-1:0]   child_5,
    output logic [INDEX_BITS-1:0]   child_6,
    output logic [INDEX_BITS-1:0]   child_7,
    output logic                    level_end
);

    localparam int unsigned CMD_BITS    = $bits(cmd_ctl_t) + PARENT_BITS + INDEX_BITS;
    localparam int unsigned REC_BITS    = INDEX_BITS + PARENT_BITS + NUM_SLOTS
                                          + NUM_SLOTS * INDEX_BITS + 1;
    // Field offsets inside a node record, from the low end.
    localparam int unsigned CH_LSB   = 1;
    localparam int unsigned OCC_LSB  = CH_LSB + NUM_SLOTS * INDEX_BITS;
    localparam int unsigned PAR_LSB  = OCC_LSB + NUM_SLOTS;
    localparam int unsigned IDX_LSB  = PAR_LSB + PARENT_BITS;

    logic                   fq_push;
    cmd_ctl_t               fq_ctl;
    logic [PARENT_BITS-1:0] fq_parent;
    logic [INDEX_BITS-1:0]  fq_child;
    logic                   cq_full;
    logic                   cq_empty;
    logic                   cq_pop;
    logic [CMD_BITS-1:0]    cq_rdata;
    cmd_ctl_t               bk_ctl;
    logic [PARENT_BITS-1:0] bk_parent;
    logic [INDEX_BITS-1:0]  bk_child;
    logic                   rec_push;
    logic [REC_BITS-1:0]    rec;
    logic                   nq_full;
    logic [REC_BITS-1:0]    head;

    assign full = cq_full;

    // Classify each request against the parent of the open group.
    olb_front #(
        .CODE_BITS   (CODE_BITS),
        .INDEX_BITS  (INDEX_BITS),
        .PARENT_BITS (PARENT_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .code     (code),
        .child    (child),
        .last     (last),
        .q_full   (cq_full),
        .q_push   (fq_push),
        .q_ctl    (fq_ctl),
        .q_parent (fq_parent),
        .q_child  (fq_child)
    );

    // Decouple the two halves; a double emit stalls the back end, and the front end only once this queue fills.
    olb_queue2 #(
        .WIDTH (CMD_BITS)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .wdata ({fq_ctl, fq_parent, fq_child}),
        .full  (cq_full),
        .pop   (cq_pop),
        .rdata (cq_rdata),
        .empty (cq_empty)
    );

    assign {bk_ctl, bk_parent, bk_child} = cq_rdata;

    // Build groups and hand finished nodes to the output buffer.
    olb_back #(
        .INDEX_BITS  (INDEX_BITS),
        .PARENT_BITS (PARENT_BITS),
        .REC_BITS    (REC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_empty  (cq_empty),
        .cmd_ctl    (bk_ctl),
        .cmd_parent (bk_parent),
        .cmd_child  (bk_child),
        .cmd_pop    (cq_pop),
        .out_full   (nq_full),
        .rec_push   (rec_push),
        .rec        (rec)
    );

    // Hold finished nodes until the consumer pops them.
    olb_queue2 #(
        .WIDTH (REC_BITS)
    ) u_node_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rec_push),
        .wdata (rec),
        .full  (nq_full),
        .pop   (pop),
        .rdata (head),
        .empty (empty)
    );

    assign node_index  = head[IDX_LSB +: INDEX_BITS];
    assign parent_code = head[PAR_LSB +: PARENT_BITS];
    assign occupancy   = head[OCC_LSB +: NUM_SLOTS];
    assign child_0     = head[CH_LSB + 0*INDEX_BITS +: INDEX_BITS];
    assign child_1     = head[CH_LSB + 1*INDEX_BITS +: INDEX_BITS];
    assign child_2     = head[CH_LSB + 2*INDEX_BITS +: INDEX_BITS];
    assign child_3     = head[CH_LSB + 3*INDEX_BITS +: INDEX_BITS];
    assign child_4     = head[CH_LSB + 4*INDEX_BITS +: INDEX_BITS];
    assign child_5     = head[CH_LSB + 5*INDEX_BITS +: INDEX_BITS];
    assign child_6     = head[CH_LSB + 6*INDEX_BITS +: INDEX_BITS];
    assign child_7     = head[CH_LSB + 7*INDEX_BITS +: INDEX_BITS];
    assign level_end   = head[0];

endmodule

// File: rtl/core/olb_checker.sv
// Port-level checks for the octree level builder and their bind.
module olb_checker #(
    parameter int unsigned INDEX_BITS = 32
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  empty,
    input logic                  pop,
    input logic [INDEX_BITS-1:0] node_index,
    input logic [7:0]            occupancy,
    input logic [INDEX_BITS-1:0] child_0,
    input logic [INDEX_BITS-1:0] child_7
);

    // A waiting node stays until popped.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("node dropped without pop");

    // A waiting node keeps its index and mask.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(node_index) && $stable(occupancy))
        else $error("waiting node changed");

    // Every emitted node has at least one child.
    a_occupied: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> occupancy != 8'd0)
        else $error("node emitted with empty occupancy");

    // Empty octants 0 and 7 read as all ones.
    a_empty_slot: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (occupancy[0] || child_0 == '1) && (occupancy[7] || child_7 == '1))
        else $error("empty octant not all ones");

endmodule

bind octree_level_builder olb_checker #(
    .INDEX_BITS (INDEX_BITS)
) u_olb_checker (.*);

// File: sim/olb_node_checker.sv
// Node checker for the octree level builder: watches both queues, predicts nodes, compares.
`timescale 1ns / 100ps

module olb_node_checker
    import olb_pkg::*;
#(
    parameter int unsigned CODE_BITS  = 63,
    parameter int unsigned INDEX_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic                    full,
    input  logic [CODE_BITS-1:0]    code,
    input  logic [INDEX_BITS-1:0]   child,
    input  logic                    last,
    input  logic                    empty,
    input  logic                    pop,
    input  logic [INDEX_BITS-1:0]   node_index,
    input  logic [CODE_BITS-4:0]    parent_code,
    input  logic [NUM_SLOTS-1:0]    occupancy,
    input  logic [INDEX_BITS-1:0]   child_0,
    input  logic [INDEX_BITS-1:0]   child_1,
    input  logic [INDEX_BITS-1:0]   child_2,
    input  logic [INDEX_BITS-1:0]   child_3,
    input  logic [INDEX_BITS-1:0]   child_4,
    input  logic [INDEX_BITS-1:0]   child_5,
    input  logic [INDEX_BITS-1:0]   child_6,
    input  logic [INDEX_BITS-1:0]   child_7,
    input  logic                    level_end,
    output int                      mismatches,
    output int                      nodes_due
);

    localparam int unsigned PARENT_BITS = CODE_BITS - 3;
    localparam logic [INDEX_BITS-1:0] EMPTY_CHILD = '1;

    typedef struct packed {
        logic [INDEX_BITS-1:0]                index;
        logic [PARENT_BITS-1:0]               parent;
        occ_t                                 occ;
        logic [NUM_SLOTS-1:0][INDEX_BITS-1:0] kids;
        logic                                 level_end;
    } node_t;

    node_t                                nodes_due_q[$];
    logic                                 group_open;
    logic [PARENT_BITS-1:0]               group_parent;
    occ_t                                 group_occ;
    logic [NUM_SLOTS-1:0][INDEX_BITS-1:0] group_kids;
    logic [INDEX_BITS-1:0]                next_node;

    task automatic clear_group();
        group_open   = 1'b0;
        group_parent = '0;
        group_occ    = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
            group_kids[i] = EMPTY_CHILD;
    endtask

    // Emit the open group as a node and allocate its index.
    task automatic close_group(input logic end_flag);
        node_t n;
        n.index     = next_node;
        n.parent    = group_parent;
        n.occ       = group_occ;
        n.kids      = group_kids;
        n.level_end = end_flag;
        nodes_due_q.insert(nodes_due_q.size(), n);
        next_node = next_node + 1'b1;
        clear_group();
    endtask

    task automatic absorb_cell(input logic [CODE_BITS-1:0] c, input logic [INDEX_BITS-1:0] ch,
                               input logic l);
        logic [PARENT_BITS-1:0] p;
        slot_t                  s;
        p = c[CODE_BITS-1:SLOT_BITS];
        s = c[SLOT_BITS-1:0];
        if (group_open && p != group_parent)
            close_group(1'b0);
        if (!group_open)
        begin
            group_open   = 1'b1;
            group_parent = p;
        end
        group_occ[s]  = 1'b1;
        group_kids[s] = ch;
        if (l)
            close_group(1'b1);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        node_t                                want;
        logic [NUM_SLOTS-1:0][INDEX_BITS-1:0] got_kids;
        if (!rst_n)
        begin
            clear_group();
            next_node  = '0;
            mismatches = 0;
            nodes_due_q.delete();
        end
        else
        begin
            if (push && !full)
                absorb_cell(code, child, last);
            if (pop && !empty)
            begin
                if (nodes_due_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: node popped with none expected, index %h parent %h",
                             $time, node_index, parent_code);
                end
                else
                begin
                    want     = nodes_due_q.pop_front();
                    got_kids = {child_7, child_6, child_5, child_4,
                                child_3, child_2, child_1, child_0};
                    check_field("node_index", 64'(want.index), 64'(node_index));
                    check_field("parent_code", 64'(want.parent), 64'(parent_code));
                    check_field("occupancy", 64'(want.occ), 64'(occupancy));
                    for (int i = 0; i < NUM_SLOTS; i++)
                        check_field($sformatf("child_%0d", i), 64'(want.kids[i]),
                                    64'(got_kids[i]));
                    check_field("level_end", 64'(want.level_end), 64'(level_end));
                end
            end
        end
        nodes_due = nodes_due_q.size();
    end

endmodule

// File: sim/tb.sv
// Testbench top for the octree level builder: clock, reset, request stimulus, verdict.
`timescale 1ns / 100ps

module tb;
    import olb_pkg::*;

    localparam int unsigned CODE_BITS   = 63;
    localparam int unsigned INDEX_BITS  = 32;
    localparam int unsigned PARENT_BITS = CODE_BITS - 3;
    localparam int          RANDOM_REQUESTS = 1450;
    localparam int          HOLD_AT      = 700;     // request count that starts the long stall
    localparam int          HOLD_CYCLES  = 250;
    localparam int          DRAIN_CYCLES = 20;      // leave slack after the last node
    localparam int          CYCLE_LIMIT  = 200000;
    localparam logic [INDEX_BITS-1:0]  ALL_ONES_CHILD = '1;
    localparam logic [CODE_BITS-1:0]   MAX_CODE       = '1;
    localparam logic [PARENT_BITS-1:0] MAX_PARENT     = '1;

    logic                    clk;
    logic                    rst_n;
    logic                    push;
    logic                    full;
    logic [CODE_BITS-1:0]    code;
    logic [INDEX_BITS-1:0]   child;
    logic                    last;
    logic                    empty;
    logic                    pop;
    logic [INDEX_BITS-1:0]   node_index;
    logic [PARENT_BITS-1:0]  parent_code;
    logic [NUM_SLOTS-1:0]    occupancy;
    logic [INDEX_BITS-1:0]   child_0;
    logic [INDEX_BITS-1:0]   child_1;
    logic [INDEX_BITS-1:0]   child_2;
    logic [INDEX_BITS-1:0]   child_3;
    logic [INDEX_BITS-1:0]   child_4;
    logic [INDEX_BITS-1:0]   child_5;
    logic [INDEX_BITS-1:0]   child_6;
    logic [INDEX_BITS-1:0]   child_7;
    logic                    level_end;
    int                      mismatches;
    int                      nodes_due;

    int  requests_sent;
    int  burst_left;
    int  cycle_count;
    bit  receiver_holding;

    octree_level_builder #(
        .CODE_BITS  (CODE_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) dut (.*);

    olb_node_checker #(
        .CODE_BITS  (CODE_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) checker_i (.*);

    // 20 ns clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: end the run if the block hangs.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Receiver: pop on a pattern of its own. Modes are redrawn at random
    // (always pop, coin flip, mostly stalled). Once, after HOLD_AT requests, hold
    // pop low for a long stretch so the node buffer and request queue fill up and
    // full rises while the sender keeps offering.
    initial
    begin
        int pop_mode;
        int mode_left;
        int hold_left;
        bit hold_done;
        pop_mode  = 0;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        receiver_holding = 1'b0;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && requests_sent >= HOLD_AT) begin
                hold_done        = 1'b1;
                hold_left        = HOLD_CYCLES;
                receiver_holding = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
                if (hold_left == 0)
                    receiver_holding = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    pop_mode  = $urandom_range(0, 2);
                    mode_left = $urandom_range(8, 80);
                end
                mode_left--;
                case (pop_mode)
                    0:       pop <= 1'b1;
                    1:       pop <= 1'($urandom_range(0, 1));
                    default: pop <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offer one request and hold it until it is taken. Bursts of random length
    // alternate with idle gaps; skip the gaps while the receiver is holding off
    // so the block is pushed into backpressure.
    task automatic send_request(input logic [CODE_BITS-1:0] c, input logic [INDEX_BITS-1:0] ch,
                                input logic l);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 6);
            if (receiver_holding || $urandom_range(0, 4) == 0)
                gap = 0;
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                @(negedge clk);
                push <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        push  <= 1'b1;
        code  <= c;
        child <= ch;
        last  <= l;
        do @(posedge clk); while (full);
        burst_left--;
        requests_sent++;
    endtask

    // Drop push and wait until every expected node has been popped.
    task automatic drain_nodes();
        @(negedge clk);
        push <= 1'b0;
        while (nodes_due != 0)
            @(negedge clk);
    endtask

    function automatic logic [INDEX_BITS-1:0] random_child();
        case ($urandom_range(0, 15))
            0, 1:    return ALL_ONES_CHILD;
            2:       return '0;
            default: return INDEX_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [PARENT_BITS-1:0] random_parent();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       return MAX_PARENT - PARENT_BITS'($urandom_range(0, 40));
            1:       return PARENT_BITS'($urandom_range(0, 40));
            default: return r[PARENT_BITS-1:0];
        endcase
    endfunction

    // One well-formed level: ascending parents, each group's octants in
    // ascending order, last on the final request. Make the final group a single
    // request half the time so a parent change coincides with last.
    task automatic send_sorted_level();
        logic [PARENT_BITS-1:0] parent;
        occ_t                   octants;
        int                     groups;
        int                     top_slot;
        groups = $urandom_range(1, 10);
        parent = random_parent();
        for (int g = 0; g < groups; g++) begin
            if (g == groups - 1 && $urandom_range(0, 1) == 1)
                octants = occ_t'(1) << $urandom_range(0, NUM_SLOTS - 1);
            else
                octants = occ_t'($urandom_range(1, 255));
            top_slot = 0;
            for (int s = 0; s < NUM_SLOTS; s++)
                if (octants[s])
                    top_slot = s;
            for (int s = 0; s < NUM_SLOTS; s++)
                if (octants[s])
                    send_request({parent, slot_t'(s)}, random_child(),
                                 g == groups - 1 && s == top_slot);
            parent = parent + PARENT_BITS'($urandom_range(1, 4));
        end
    endtask

    // Broken sequences: random codes in any order, repeated cells, siblings split
    // by strangers, and last at random places.
    task automatic send_noise_level();
        logic [CODE_BITS-1:0] c;
        int                   n;
        c = {random_parent(), slot_t'($urandom_range(0, NUM_SLOTS - 1))};
        n = $urandom_range(1, 16);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0:       c = {random_parent(), slot_t'($urandom_range(0, NUM_SLOTS - 1))};
                1:       c = c;
                default: c[SLOT_BITS-1:0] = slot_t'($urandom_range(0, NUM_SLOTS - 1));
            endcase
            send_request(c, random_child(), i == n - 1 || $urandom_range(0, 7) == 0);
        end
    endtask

    // Stimulus: directed cases, then random levels, then drain and verdict.
    initial
    begin
        logic [PARENT_BITS-1:0] p;
        int                     levels;
        rst_n         = 1'b0;
        push          = 1'b0;
        code          = '0;
        child         = '0;
        last          = 1'b0;
        requests_sent = 0;
        burst_left    = 0;
        levels        = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Lowest code and child, then octant 7 of the same parent with an
        // all-ones child.
        send_request('0, '0, 1'b0);
        send_request(CODE_BITS'(7), ALL_ONES_CHILD, 1'b0);
        // Repeated octant: the later child overwrites.
        send_request(CODE_BITS'(3), 32'h1234_5678, 1'b0);
        send_request(CODE_BITS'(3), 32'h8765_4321, 1'b0);
        // Parent change together with last: two nodes, the second ends the level.
        send_request({PARENT_BITS'(1), slot_t'(5)}, 32'h0000_0001, 1'b1);
        // Last with nothing open: the request alone makes a node; highest code.
        send_request(MAX_CODE, '0, 1'b1);
        // Out-of-order parents: each change starts a fresh node, nothing merged.
        send_request({PARENT_BITS'(5), slot_t'(1)}, 32'hAAAA_AAAA, 1'b0);
        send_request({PARENT_BITS'(2), slot_t'(0)}, 32'h5555_5555, 1'b0);
        send_request({PARENT_BITS'(5), slot_t'(2)}, 32'hFFFF_FFFE, 1'b0);
        // Last within the open group: a single node.
        send_request({PARENT_BITS'(5), slot_t'(6)}, 32'h8000_0000, 1'b1);
        // All eight octants of the highest parent.
        p = MAX_PARENT;
        for (int s = 0; s < NUM_SLOTS; s++)
            send_request({p, slot_t'(s)}, INDEX_BITS'($urandom), s == NUM_SLOTS - 1);
        // Pause until every node is out before the random part.
        drain_nodes();

        while (requests_sent < RANDOM_REQUESTS + 18)
        begin
            levels++;
            if (levels % 40 == 0)
                drain_nodes();
            if ($urandom_range(0, 9) == 0)
                send_noise_level();
            else
                send_sorted_level();
        end

        drain_nodes();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
